### sv/ids_pkg.sv
// ----------------------------------------------------------------------------
// ids_pkg
// Shared types and codes for the item dispenser sequencer.
// ----------------------------------------------------------------------------
package ids_pkg;

  localparam int CountW     = 16;
  localparam int StableW    = 8;
  localparam int StepW      = 32;
  localparam int SpeedW     = 16;
  localparam int TargetW    = 8;
  localparam int CfgIndexW  = 3;
  localparam int CfgDataW   = 32;
  localparam int InTdataW   = 32;
  localparam int InTuserW   = 3;
  localparam int OutTdataW  = 56;

  typedef enum logic [2:0] {
    KIND_BEAM    = 3'd0,
    KIND_SWITCH  = 3'd1,
    KIND_STEP    = 3'd2,
    KIND_START   = 3'd3,
    KIND_HOME    = 3'd4,
    KIND_DISABLE = 3'd5,
    KIND_HOLD    = 3'd6,
    KIND_QUEUE   = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DISP = 2'd1,
    PH_STAB = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    MOT_NONE    = 2'd0,
    MOT_MOVE    = 2'd1,
    MOT_DISABLE = 2'd2,
    MOT_HOLD    = 2'd3
  } motor_cmd_e;

  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_HOME = 2'd1,
    SEL_MOVE = 2'd2
  } sel_cmd_e;

  typedef enum logic [3:0] {
    EVT_NONE         = 4'd0,
    EVT_NOT_HOMED    = 4'd1,
    EVT_BAD_COUNT    = 4'd2,
    EVT_STARTED      = 4'd3,
    EVT_ITEM         = 4'd4,
    EVT_DONE         = 4'd5,
    EVT_OVERRUN      = 4'd6,
    EVT_HOMING       = 4'd7,
    EVT_ALREADY_HOME = 4'd8,
    EVT_HOMED        = 4'd9,
    EVT_DISABLED     = 4'd10,
    EVT_HELD         = 4'd11
  } event_e;

  localparam logic [CfgIndexW-1:0] CFG_STABLE_NEEDED = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_TOO_FAR_STEPS = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_DISP_SPEED    = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_DISP_DIR      = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_HOME_SPEED    = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_HOME_DIR      = 3'd5;

  typedef struct packed {
    kind_e              kind;
    logic               beam_broken;
    logic               switch_pressed;
    logic [CountW-1:0]  item_count;
    logic               skip_homing;
    logic [1:0]         selector_action;
    logic [TargetW-1:0] selector_position;
  } item_t;

  typedef struct packed {
    motor_cmd_e         motor_command;
    logic [SpeedW-1:0]  motor_speed;
    logic               motor_direction;
    event_e             event_res;
    logic [CountW-1:0]  items_remaining;
    logic               is_homed;
    sel_cmd_e           selector_command;
    logic [TargetW-1:0] selector_target;
  } result_t;

endpackage

### sv/ids_ctrl.sv
// ----------------------------------------------------------------------------
// ids_ctrl
// Sequencer state, configuration registers and one-item step logic.
// ----------------------------------------------------------------------------
module ids_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ids_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [ids_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            step_en_i,
  input  ids_pkg::item_t                  item_i,
  output ids_pkg::result_t                res_o
);
  import ids_pkg::*;

  logic [StableW-1:0] stable_needed_q;
  logic [StepW-1:0]   too_far_q;
  logic [SpeedW-1:0]  disp_speed_q;
  logic               disp_dir_q;
  logic [SpeedW-1:0]  home_speed_q;
  logic               home_dir_q;

  phase_e             phase_q, phase_d;
  logic               homing_active_q, homing_active_d;
  logic               homed_q, homed_d;
  logic               switch_level_q, switch_level_d;
  logic               no_home_after_q, no_home_after_d;
  logic [CountW-1:0]  items_left_q, items_left_d;
  logic [StableW-1:0] settle_cnt_q, settle_cnt_d;
  logic [StepW-1:0]   step_pos_q, step_pos_d;
  logic [1:0]         pend_action_q, pend_action_d;
  logic [TargetW-1:0] pend_target_q, pend_target_d;

  logic [CountW-1:0]  items_dec;
  logic [StableW-1:0] stable_new;
  logic               end_run;
  result_t            res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_needed_q <= StableW'(10);
      too_far_q       <= StepW'(100000);
      disp_speed_q    <= SpeedW'(100);
      disp_dir_q      <= 1'b0;
      home_speed_q    <= SpeedW'(100);
      home_dir_q      <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STABLE_NEEDED: stable_needed_q <= cfg_data_i[StableW-1:0];
        CFG_TOO_FAR_STEPS: too_far_q       <= cfg_data_i[StepW-1:0];
        CFG_DISP_SPEED:    disp_speed_q    <= cfg_data_i[SpeedW-1:0];
        CFG_DISP_DIR:      disp_dir_q      <= cfg_data_i[0];
        CFG_HOME_SPEED:    home_speed_q    <= cfg_data_i[SpeedW-1:0];
        CFG_HOME_DIR:      home_dir_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d         = phase_q;
    homing_active_d = homing_active_q;
    homed_d         = homed_q;
    switch_level_d  = switch_level_q;
    no_home_after_d = no_home_after_q;
    items_left_d    = items_left_q;
    settle_cnt_d    = settle_cnt_q;
    step_pos_d      = step_pos_q;
    pend_action_d   = pend_action_q;
    pend_target_d   = pend_target_q;
    items_dec       = items_left_q - CountW'(1);
    stable_new      = settle_cnt_q;
    end_run         = 1'b0;

    res = '0;
    res.motor_command    = MOT_NONE;
    res.event_res        = EVT_NONE;
    res.selector_command = SEL_NONE;

    unique case (item_i.kind)
      KIND_BEAM: begin
        if (phase_q == PH_DISP) begin
          if (item_i.beam_broken) begin
            res.motor_command = MOT_DISABLE;
            items_left_d      = items_dec;
            if (items_dec == '0) begin
              end_run       = 1'b1;
              res.event_res = EVT_DONE;
            end else begin
              res.event_res = EVT_ITEM;
              phase_d       = PH_STAB;
              settle_cnt_d  = '0;
            end
          end else if (step_pos_q >= too_far_q) begin
            end_run       = 1'b1;
            res.event_res = EVT_OVERRUN;
          end
        end else if (phase_q == PH_STAB) begin
          if (item_i.beam_broken) begin
            stable_new = '0;
          end else if (settle_cnt_q != '1) begin
            stable_new = settle_cnt_q + StableW'(1);
          end
          if (stable_new >= stable_needed_q) begin
            res.motor_command   = MOT_MOVE;
            res.motor_speed     = disp_speed_q;
            res.motor_direction = disp_dir_q;
            phase_d             = PH_DISP;
            settle_cnt_d        = '0;
          end else begin
            settle_cnt_d = stable_new;
          end
        end
      end
      KIND_SWITCH: begin
        switch_level_d = item_i.switch_pressed;
        if (item_i.switch_pressed) begin
          homed_d = 1'b0;
        end else if (homing_active_q) begin
          res.motor_command = MOT_DISABLE;
          homing_active_d   = 1'b0;
          homed_d           = 1'b1;
          res.event_res     = EVT_HOMED;
          if (pend_action_q == SEL_HOME) begin
            res.selector_command = SEL_HOME;
          end else if (pend_action_q == SEL_MOVE) begin
            res.selector_command = SEL_MOVE;
            res.selector_target  = pend_target_q;
          end
          pend_action_d = '0;
        end
      end
      KIND_STEP: begin
        if (phase_q != PH_IDLE && step_pos_q != '1) begin
          step_pos_d = step_pos_q + StepW'(1);
        end
      end
      KIND_START: begin
        if (item_i.skip_homing) begin
          no_home_after_d = 1'b1;
        end
        if (switch_level_q) begin
          res.event_res = EVT_NOT_HOMED;
        end else if (item_i.item_count == '0) begin
          res.event_res = EVT_BAD_COUNT;
        end else begin
          items_left_d        = item_i.item_count;
          step_pos_d          = '0;
          settle_cnt_d        = '0;
          phase_d             = PH_DISP;
          res.motor_command   = MOT_MOVE;
          res.motor_speed     = disp_speed_q;
          res.motor_direction = disp_dir_q;
          res.event_res       = EVT_STARTED;
        end
      end
      KIND_HOME: begin
        if (!homed_q) begin
          homing_active_d     = 1'b1;
          res.motor_command   = MOT_MOVE;
          res.motor_speed     = home_speed_q;
          res.motor_direction = home_dir_q;
          res.event_res       = EVT_HOMING;
        end else begin
          res.event_res = EVT_ALREADY_HOME;
        end
      end
      KIND_DISABLE: begin
        res.motor_command = MOT_DISABLE;
        phase_d           = PH_IDLE;
        res.event_res     = EVT_DISABLED;
      end
      KIND_HOLD: begin
        res.motor_command = MOT_HOLD;
        res.event_res     = EVT_HELD;
      end
      KIND_QUEUE: begin
        pend_action_d = item_i.selector_action;
        pend_target_d = item_i.selector_position;
      end
      default: ;
    endcase

    // run end: drop to idle, then home unless skip was requested
    if (end_run) begin
      phase_d         = PH_IDLE;
      homed_d         = 1'b0;
      no_home_after_d = 1'b0;
      if (!no_home_after_q) begin
        homing_active_d     = 1'b1;
        res.motor_command   = MOT_MOVE;
        res.motor_speed     = home_speed_q;
        res.motor_direction = home_dir_q;
      end else begin
        res.motor_command = MOT_DISABLE;
      end
    end

    res.items_remaining = items_left_d;
    res.is_homed        = homed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      homing_active_q <= 1'b0;
      homed_q         <= 1'b1;
      switch_level_q  <= 1'b0;
      no_home_after_q <= 1'b0;
      items_left_q    <= '0;
      settle_cnt_q    <= '0;
      step_pos_q      <= '0;
      pend_action_q   <= '0;
      pend_target_q   <= '0;
    end else if (step_en_i) begin
      phase_q         <= phase_d;
      homing_active_q <= homing_active_d;
      homed_q         <= homed_d;
      switch_level_q  <= switch_level_d;
      no_home_after_q <= no_home_after_d;
      items_left_q    <= items_left_d;
      settle_cnt_q    <= settle_cnt_d;
      step_pos_q      <= step_pos_d;
      pend_action_q   <= pend_action_d;
      pend_target_q   <= pend_target_d;
    end
  end

  assign res_o = res;

  a_move_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res.motor_command != MOT_MOVE |->
      res.motor_speed == '0 && res.motor_direction == 1'b0)
    else $error("motor speed or direction set without a move");

  a_target_only_on_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res.selector_target != '0 |-> res.selector_command == SEL_MOVE)
    else $error("selector target set without a move");

  a_hold_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && item_i.kind == KIND_HOLD |=>
      $stable(phase_q) && $stable(items_left_q) && $stable(homed_q))
    else $error("hold changed sequencer state");

  a_homed_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res.event_res == EVT_HOMED |=>
      !homing_active_q && homed_q && pend_action_q == '0)
    else $error("homed event left homing state behind");

  a_stab_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DISP |-> settle_cnt_q == '0)
    else $error("settle count nonzero while dispensing");

endmodule

### sv/item_dispenser_sequencer.sv
// ----------------------------------------------------------------------------
// item_dispenser_sequencer
// Dispense, homing and selector-release sequencer with one result per item.
// ----------------------------------------------------------------------------
// Input items (commands, beam samples, switch changes, step ticks) arrive on
// the s_axis channel, with the item kind in tuser. Every accepted item gives
// exactly one result on the m_axis channel: motor command, event code, items
// left, homed flag and any released selector action.
// An item is registered in the input register at its transfer, evaluated
// against the sequencer state and written to the output register, from
// which its result is offered on m_axis. One item per cycle is taken without
// gaps while m_axis_tready stays high; the state is updated once per item.
// The output register is held while m_axis_tready is low; one item waits in
// the input register, after which s_axis_tready drops until the result moves.
// Registers are written through cfg_we_i/cfg_index_i/cfg_data_i; the user must write them only while idle,
// the block itself does not enforce this. Reset loads the register defaults and leaves the block idle, homed,
// with the switch released and no selector action pending.
// ----------------------------------------------------------------------------
module item_dispenser_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ids_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [ids_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // beam_broken, switch_pressed, item_count, skip_homing, selector_action,
  // selector_position
  input  logic [ids_pkg::InTdataW-1:0]    s_axis_tdata,
  // kind
  input  logic [ids_pkg::InTuserW-1:0]    s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // motor_command, motor_speed, motor_direction, event_res, items_remaining,
  // is_homed, selector_command, selector_target
  output logic [ids_pkg::OutTdataW-1:0]   m_axis_tdata
);
  import ids_pkg::*;

  item_t   in_item;
  item_t   in_q;
  logic    in_valid_q;
  result_t res;
  result_t out_q;
  logic    out_valid_q;
  logic    step_en;

  assign in_item.kind              = kind_e'(s_axis_tuser);
  assign in_item.beam_broken       = s_axis_tdata[0];
  assign in_item.switch_pressed    = s_axis_tdata[1];
  assign in_item.item_count        = s_axis_tdata[17:2];
  assign in_item.skip_homing       = s_axis_tdata[18];
  assign in_item.selector_action   = s_axis_tdata[20:19];
  assign in_item.selector_position = s_axis_tdata[28:21];

  assign step_en       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_item;
    end
  end

  ids_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_en_i   (step_en),
    .item_i      (in_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_en) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.selector_target, out_q.selector_command,
                          out_q.is_homed, out_q.items_remaining, out_q.event_res,
                          out_q.motor_direction, out_q.motor_speed,
                          out_q.motor_command};

endmodule
